FILE: hdl/nrcp_pkg.sv
// Shared types, constants and start-value table for the Newton reciprocal block.
package nrcp_pkg;

    localparam int FRACTION_BITS = 62;
    localparam int DIVISOR_WIDTH = 32;

    localparam int X_W       = 63;
    localparam int TOL_W     = 62;
    localparam int LIM_W     = 6;
    localparam int CFG_IDX_W = 2;
    localparam int OP_W      = 64;
    localparam int PROD_W    = 2 * OP_W;
    localparam int P_W       = DIVISOR_WIDTH + X_W;

    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORDER_MODE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ITER_LIMIT = 2'd2;

    localparam logic [TOL_W-1:0] TOL_RESET =
        TOL_W'((64'd1 << FRACTION_BITS) / 64'd100000000);
    localparam logic [LIM_W-1:0] LIMIT_RESET = 6'd63;

    localparam logic [OP_W-1:0] ONE_FX  = 64'd1 << FRACTION_BITS;
    localparam logic [OP_W-1:0] TWO_FX  = ONE_FX << 1;
    localparam logic [OP_W-1:0] H_CLAMP = 64'h8000_0000_0000_0000;
    localparam logic [X_W-1:0]  X_MAX   = '1;

    localparam logic [63:0] POW_TEN [10] = '{
        64'd1, 64'd10, 64'd100, 64'd1000, 64'd10000, 64'd100000,
        64'd1000000, 64'd10000000, 64'd100000000, 64'd1000000000
    };

    // floor(2^62 / (5 * 10^k))
    localparam logic [X_W-1:0] START_TAB [10] = '{
        63'd922337203685477580, 63'd92233720368547758, 63'd9223372036854775,
        63'd922337203685477,    63'd92233720368547,    63'd9223372036854,
        63'd922337203685,       63'd92233720368,       63'd9223372036,
        63'd922337203
    };

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ISSUE_AY,
        ST_WAIT_AY,
        ST_FACT,
        ST_WAIT_SQ,
        ST_ISSUE_SX,
        ST_WAIT_X,
        ST_TEST,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic start;
        logic wide;
    } t_mul_req;

    // 0.2 * 10^-k, k = decimal digits of a minus one
    function automatic logic [X_W-1:0] start_value(input logic [DIVISOR_WIDTH-1:0] a);
        logic [3:0] k;
        k = '0;
        for (int j = 1; j < 10; j++) begin
            if (64'(a) >= POW_TEN[j]) begin
                k = k + 4'd1;
            end
        end
        return START_TAB[k] >> (62 - FRACTION_BITS);
    endfunction

endpackage

FILE: hdl/nrcp_mul.sv
// Shared 64x64 multiplier built from one 32x32 multiplier over two or four partial products.
module nrcp_mul
    import nrcp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_mul_req          i_req,
    input  logic [OP_W-1:0]   i_op_a,
    input  logic [OP_W-1:0]   i_op_b,
    output logic              o_done,
    output logic [PROD_W-1:0] o_product
);

    logic              r_busy;
    logic [1:0]        r_idx;
    logic [1:0]        r_last;
    logic [OP_W-1:0]   r_a;
    logic [OP_W-1:0]   r_b;
    logic [OP_W-1:0]   r_pp;
    logic [1:0]        r_pp_sh;
    logic              r_pp_vld;
    logic              r_pp_last;
    logic [PROD_W-1:0] r_acc;
    logic              r_done;

    logic [31:0]       a_sel;
    logic [31:0]       b_sel;
    logic [PROD_W-1:0] pp_shifted;

    assign a_sel = r_idx[1] ? r_a[63:32] : r_a[31:0];
    assign b_sel = r_idx[0] ? r_b[63:32] : r_b[31:0];

    always_comb begin
        case (r_pp_sh)
            2'd0:    pp_shifted = {64'd0, r_pp};
            2'd1:    pp_shifted = {32'd0, r_pp, 32'd0};
            2'd2:    pp_shifted = {r_pp, 64'd0};
            default: pp_shifted = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_pp_vld <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_pp_vld <= r_busy;
            r_done   <= r_pp_vld & r_pp_last;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_idx == r_last) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a    <= i_op_a;
            r_b    <= i_op_b;
            r_idx  <= 2'd0;
            r_last <= i_req.wide ? 2'd3 : 2'd1;
            r_acc  <= '0;
        end else begin
            if (r_busy) begin
                r_idx <= r_idx + 2'd1;
            end
            if (r_pp_vld) begin
                r_acc <= r_acc + pp_shifted;
            end
        end
        if (r_busy) begin
            r_pp      <= a_sel * b_sel;
            r_pp_sh   <= {1'b0, r_idx[1]} + {1'b0, r_idx[0]};
            r_pp_last <= (r_idx == r_last);
        end
    end

    assign o_done    = r_done;
    assign o_product = r_acc;

endmodule

FILE: hdl/newton_reciprocal.sv
// Newton-Raphson reciprocal: sequencer, iteration datapath, config registers and output register.
//
// One divisor word in, one reciprocal word out (2^62 is 1.0). The block holds
// o_in_ready low while it works on a word and takes the next one as soon as the
// result sits in the output register, even if that word is not yet taken.
// Every product goes through a single 32x32 multiplier, a*y in two partial
// products and the 64x64 products in four, each summed into an accumulator
// register. A zero divisor or a zero iteration_limit goes straight to the
// finish state. Configuration writes belong in idle periods only.
module newton_reciprocal
    import nrcp_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [TOL_W-1:0]         i_cfg_data,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [31:0]              i_divisor,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [X_W-1:0]           o_reciprocal,
    output logic [LIM_W-1:0]         o_iterations_used,
    output logic                     o_converged
);

    t_state r_state, n_state;

    logic [TOL_W-1:0]         r_tol;
    logic                     r_mode;
    logic [LIM_W-1:0]         r_limit;

    logic [DIVISOR_WIDTH-1:0] r_a, n_a;
    logic [X_W-1:0]           r_x, n_x;
    logic [X_W-1:0]           r_y, n_y;
    logic [P_W-1:0]           r_p, n_p;
    logic [OP_W-1:0]          r_m, n_m;
    logic                     r_neg, n_neg;
    logic [OP_W-1:0]          r_s, n_s;
    logic [LIM_W-1:0]         r_n, n_n;
    logic                     r_conv, n_conv;

    logic                     r_out_valid, n_out_valid;
    logic [X_W-1:0]           r_out_recip;
    logic [LIM_W-1:0]         r_out_iter;
    logic                     r_out_conv;

    t_mul_req                 mul_req;
    logic [OP_W-1:0]          mul_op_a;
    logic [OP_W-1:0]          mul_op_b;
    logic                     mul_done;
    logic [PROD_W-1:0]        mul_prod;

    logic                     out_load;
    logic                     in_take;
    logic [OP_W-1:0]          fact_t;
    logic [OP_W-1:0]          fact_m;
    logic                     fact_neg;
    logic [P_W-1:0]           p_diff;
    logic [PROD_W-1:0]        prod_sh;
    logic [PROD_W-1:0]        s_wide;
    logic [OP_W-1:0]          s_val;
    logic [X_W-1:0]           x_val;
    logic [X_W-1:0]           d_val;
    logic                     conv_val;
    logic [LIM_W-1:0]         n_inc;

    nrcp_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (mul_req),
        .i_op_a    (mul_op_a),
        .i_op_b    (mul_op_b),
        .o_done    (mul_done),
        .o_product (mul_prod)
    );

    // factor for the second product: 2 - a*y, or h = |1 - a*y| with its sign
    always_comb begin
        fact_t   = (r_p >= P_W'(TWO_FX)) ? '0 : TWO_FX - r_p[OP_W-1:0];
        p_diff   = r_p - P_W'(ONE_FX);
        fact_neg = (r_p > P_W'(ONE_FX));
        if (!fact_neg) begin
            fact_m = ONE_FX - r_p[OP_W-1:0];
        end else if (p_diff > P_W'(H_CLAMP)) begin
            fact_m = H_CLAMP;
        end else begin
            fact_m = p_diff[OP_W-1:0];
        end
    end

    // 1 + h + h*h, clamped to 64 bits; new x from the product, clamped to 63 bits
    always_comb begin
        prod_sh = mul_prod >> FRACTION_BITS;
        if (r_neg) begin
            s_wide = prod_sh + PROD_W'(ONE_FX) - PROD_W'(r_m);
        end else begin
            s_wide = prod_sh + PROD_W'(ONE_FX) + PROD_W'(r_m);
        end
        s_val = (s_wide[PROD_W-1:OP_W] != '0) ? '1 : s_wide[OP_W-1:0];
        x_val = (prod_sh[PROD_W-1:X_W] != '0) ? X_MAX : prod_sh[X_W-1:0];
    end

    // stop test
    always_comb begin
        d_val    = (r_x >= r_y) ? (r_x - r_y) : (r_y - r_x);
        conv_val = r_mode ? (r_m <= OP_W'(r_tol)) : (d_val <= X_W'(r_tol));
        n_inc    = r_n + LIM_W'(1);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                if (r_a == '0 || r_limit == '0) begin
                    n_state = ST_FINISH;
                end else begin
                    n_state = ST_ISSUE_AY;
                end
            end
            ST_ISSUE_AY: n_state = ST_WAIT_AY;
            ST_WAIT_AY: begin
                if (mul_done) begin
                    n_state = ST_FACT;
                end
            end
            ST_FACT: n_state = r_mode ? ST_WAIT_SQ : ST_WAIT_X;
            ST_WAIT_SQ: begin
                if (mul_done) begin
                    n_state = ST_ISSUE_SX;
                end
            end
            ST_ISSUE_SX: n_state = ST_WAIT_X;
            ST_WAIT_X: begin
                if (mul_done) begin
                    n_state = ST_TEST;
                end
            end
            ST_TEST: begin
                if (conv_val || n_inc == r_limit) begin
                    n_state = ST_FINISH;
                end else begin
                    n_state = ST_ISSUE_AY;
                end
            end
            ST_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        mul_req.start = 1'b0;
        mul_req.wide  = 1'b1;
        mul_op_a      = {1'b0, r_y};
        mul_op_b      = r_s;
        o_in_ready    = 1'b0;
        out_load      = 1'b0;
        case (r_state)
            ST_IDLE: o_in_ready = 1'b1;
            ST_ISSUE_AY: begin
                mul_req.start = 1'b1;
                mul_req.wide  = 1'b0;
                mul_op_a      = OP_W'(r_a);
                mul_op_b      = {1'b0, r_x};
            end
            ST_FACT: begin
                mul_req.start = 1'b1;
                mul_op_a      = r_mode ? fact_m : {1'b0, r_y};
                mul_op_b      = r_mode ? fact_m : fact_t;
            end
            ST_ISSUE_SX: begin
                mul_req.start = 1'b1;
                mul_op_a      = {1'b0, r_y};
                mul_op_b      = r_s;
            end
            ST_FINISH: out_load = !r_out_valid || i_out_ready;
            default: ;
        endcase
    end

    assign in_take = o_in_ready && i_in_valid;

    // datapath next values
    always_comb begin
        n_a    = r_a;
        n_x    = r_x;
        n_y    = r_y;
        n_p    = r_p;
        n_m    = r_m;
        n_neg  = r_neg;
        n_s    = r_s;
        n_n    = r_n;
        n_conv = r_conv;
        if (in_take) begin
            n_a = i_divisor[DIVISOR_WIDTH-1:0];
        end
        case (r_state)
            ST_LOAD: begin
                n_x    = (r_a == '0) ? X_MAX : start_value(r_a);
                n_n    = '0;
                n_conv = 1'b0;
            end
            ST_ISSUE_AY: n_y = r_x;
            ST_WAIT_AY: begin
                if (mul_done) begin
                    n_p = mul_prod[P_W-1:0];
                end
            end
            ST_FACT: begin
                n_m   = r_mode ? fact_m : fact_t;
                n_neg = fact_neg;
            end
            ST_WAIT_SQ: begin
                if (mul_done) begin
                    n_s = s_val;
                end
            end
            ST_WAIT_X: begin
                if (mul_done) begin
                    n_x = x_val;
                end
            end
            ST_TEST: begin
                n_n    = n_inc;
                n_conv = conv_val;
            end
            default: ;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_tol       <= TOL_RESET;
            r_mode      <= 1'b0;
            r_limit     <= LIMIT_RESET;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_TOLERANCE:  r_tol   <= i_cfg_data;
                    CFG_ORDER_MODE: r_mode  <= i_cfg_data[0];
                    CFG_ITER_LIMIT: r_limit <= i_cfg_data[LIM_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_a    <= n_a;
        r_x    <= n_x;
        r_y    <= n_y;
        r_p    <= n_p;
        r_m    <= n_m;
        r_neg  <= n_neg;
        r_s    <= n_s;
        r_n    <= n_n;
        r_conv <= n_conv;
        if (out_load) begin
            r_out_recip <= r_x;
            r_out_iter  <= r_n;
            r_out_conv  <= r_conv;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_reciprocal      = r_out_recip;
    assign o_iterations_used = r_out_iter;
    assign o_converged       = r_out_conv;

endmodule
